### hw/rtl/rha_pkg.sv
// ============================================================================
// rha_pkg
// Shared types, field widths and codes of the RMSSD accumulator.
// ============================================================================
package rha_pkg;

    // Field widths of the input and result words
    localparam int INTERVAL_W  = 22;
    localparam int ROOT_OUT_W  = 26;
    localparam int COUNT_OUT_W = 16;
    localparam int STATUS_W    = 2;

    // Internal arithmetic widths
    localparam int SUM_W  = 64;   // sum of squares and scaled mean
    localparam int ROOT_W = 32;   // full square root of a 64-bit value

    // Parameter defaults
    localparam int DEF_INTERVAL_BITS = 22;
    localparam int DEF_MAX_DIFFS     = 65535;
    localparam int DEF_FRAC_BITS     = 4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TOO_FEW  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_MANY = 2'd2;

    typedef struct packed {
        logic [INTERVAL_W-1:0] interval_us;
        logic                  last;
    } in_item_t;

    typedef struct packed {
        logic [ROOT_OUT_W-1:0]  rmssd_q4;
        logic [COUNT_OUT_W-1:0] diff_count;
        logic [STATUS_W-1:0]    status;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQUARE,
        ST_ACCUM,
        ST_LOAD,
        ST_DIVIDE,
        ST_ROOT,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic diff;
        logic square;
        logic accum;
        logic div_start;
        logic sqrt_start;
        logic emit;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last;
        logic count_zero;
        logic div_done;
        logic sqrt_done;
        logic out_busy;
    } ctrl_sts_t;

endpackage

### hw/rtl/rmssd_hrv_accumulator_core.sv
// ============================================================================
// rmssd_hrv_accumulator_core
// RMSSD of a record of RR intervals, fixed point, one interval per word.
// ============================================================================
// Each input word carries one RR interval in microseconds; the word with last
// set closes the record and produces one result word: floor(sqrt(q)) with
// q = floor(sum of squared successive differences * 2^(2*FRAC_BITS) / count),
// the difference count, and a status (ok, too few intervals, too many
// differences). Each interval passes through the capture, difference, square
// and accumulate steps. On the final interval of a record the divider then
// produces one quotient bit per cycle over 64 + 2*FRAC_BITS bits and the
// square root one root bit per cycle over 32 bits, followed by any wait for
// the output register to be emptied. The next interval is taken while a
// finished result still sits in the output register.
// ============================================================================
module rmssd_hrv_accumulator_core #(
    parameter int INTERVAL_BITS = rha_pkg::DEF_INTERVAL_BITS,
    parameter int MAX_DIFFS     = rha_pkg::DEF_MAX_DIFFS,
    parameter int FRAC_BITS     = rha_pkg::DEF_FRAC_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rha_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output rha_pkg::out_item_t m_item
);

    rha_pkg::ctrl_cmd_t cmd;
    rha_pkg::ctrl_sts_t sts;

    rha_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rha_datapath #(
        .INTERVAL_BITS (INTERVAL_BITS),
        .MAX_DIFFS     (MAX_DIFFS),
        .FRAC_BITS     (FRAC_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // One word at a time: no new word in the cycle after an accepted one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted on consecutive cycles");

    // A short record reports zero root and zero count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.status == rha_pkg::STATUS_TOO_FEW) |->
        (m_item.rmssd_q4 == '0 && m_item.diff_count == '0))
        else $error("too-few result with non-zero fields");

    // A saturated record reports the full count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.status == rha_pkg::STATUS_TOO_MANY) |->
        (m_item.diff_count == rha_pkg::COUNT_OUT_W'(MAX_DIFFS)))
        else $error("too-many result without a saturated count");

    // An ok result always has at least one difference behind it
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.status == rha_pkg::STATUS_OK) |->
        (m_item.diff_count != '0))
        else $error("ok result with zero differences");

endmodule

### hw/rtl/rha_divider.sv
// ============================================================================
// rha_divider
// Restoring divider, one quotient bit per cycle, for the scaled mean.
// ============================================================================
module rha_divider #(
    parameter int DIVD_W  = rha_pkg::SUM_W + 2 * rha_pkg::DEF_FRAC_BITS,
    parameter int DIVS_W  = $clog2(rha_pkg::DEF_MAX_DIFFS + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic              done,
    output logic [DIVD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DIVD_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVS_W-1:0] dvs_reg, dvs_next;
    logic [DIVD_W-1:0] quot_reg, quot_next;

    logic [DIVS_W:0]   rem_sh;
    logic              fits;

    // Trial subtract of the divisor from the shifted partial remainder
    always_comb begin
        rem_sh = {rem_reg, quot_reg[DIVD_W-1]};
        fits   = (rem_sh >= {1'b0, dvs_reg});
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quot_next = quot_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIVD_W);
            rem_next  = '0;
            dvs_next  = divisor;
            quot_next = dividend;
        end else if (busy_reg) begin
            // dividend bits shift out at the top, quotient bits in at the bottom
            rem_next  = fits ? DIVS_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[DIVS_W-1:0];
            quot_next = {quot_reg[DIVD_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

### hw/rtl/rha_sqrt.sv
// ============================================================================
// rha_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ============================================================================
module rha_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [rha_pkg::SUM_W-1:0]   radicand,
    output logic                        done,
    output logic [rha_pkg::ROOT_W-1:0]  root
);

    localparam int RAD_W  = rha_pkg::SUM_W;
    localparam int RT_W   = rha_pkg::ROOT_W;
    localparam int REM_W  = RT_W + 2;
    localparam int STEP_W = $clog2(RT_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [RT_W-1:0]   root_reg, root_next;

    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              fits;

    // Bring down two radicand bits, try (4*root + 1)
    always_comb begin
        rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial  = (REM_W + 2)'({root_reg, 2'b01});
        fits   = (rem_sh >= trial);
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(RT_W);
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            rad_next  = rad_reg << 2;
            rem_next  = fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
            root_next = {root_reg[RT_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### hw/rtl/rha_datapath.sv
// ============================================================================
// rha_datapath
// Record state, difference/square/accumulate path, divide and root units,
// and the result output register.
// ============================================================================
module rha_datapath #(
    parameter int INTERVAL_BITS = rha_pkg::DEF_INTERVAL_BITS,
    parameter int MAX_DIFFS     = rha_pkg::DEF_MAX_DIFFS,
    parameter int FRAC_BITS     = rha_pkg::DEF_FRAC_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rha_pkg::ctrl_cmd_t  cmd,
    output rha_pkg::ctrl_sts_t  sts,
    input  rha_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output rha_pkg::out_item_t  m_item
);

    localparam int PREV_W  = (INTERVAL_BITS < rha_pkg::INTERVAL_W) ?
                             INTERVAL_BITS : rha_pkg::INTERVAL_W;
    localparam int PROD_W  = 2 * PREV_W;
    localparam int SUM_W   = rha_pkg::SUM_W;
    localparam int COUNT_W = $clog2(MAX_DIFFS + 1);
    localparam int DIVD_W  = SUM_W + 2 * FRAC_BITS;
    localparam int ROOT_W  = rha_pkg::ROOT_W;
    localparam int ROOT_OUT_W = rha_pkg::ROOT_OUT_W;

    // Per-item working registers
    logic [PREV_W-1:0]  cur_reg, cur_next;
    logic               last_reg, last_next;
    logic [PREV_W-1:0]  diff_reg, diff_next;
    logic [PROD_W-1:0]  sq_reg, sq_next;

    // Record state
    logic [PREV_W-1:0]  prev_reg, prev_next;
    logic               have_prev_reg, have_prev_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               ovf_reg, ovf_next;

    // Output register
    logic               m_valid_reg, m_valid_next;
    rha_pkg::out_item_t m_item_reg, m_item_next;

    // Divide and root
    logic [DIVD_W-1:0]  div_dividend;
    logic [DIVD_W-1:0]  div_quot;
    logic               div_done;
    logic [SUM_W-1:0]   mean;
    logic [ROOT_W-1:0]  root;
    logic               sqrt_done;
    logic [ROOT_OUT_W-1:0] root_sat;

    // Accumulation path: capture, |cur - prev|, square, add
    always_comb begin
        cur_next       = cmd.capture ? s_item.interval_us[PREV_W-1:0] : cur_reg;
        last_next      = cmd.capture ? s_item.last : last_reg;
        diff_next      = diff_reg;
        sq_next        = sq_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;

        if (cmd.diff) begin
            diff_next = (cur_reg >= prev_reg) ? (cur_reg - prev_reg) : (prev_reg - cur_reg);
        end
        if (cmd.square) begin
            sq_next = {{PREV_W{1'b0}}, diff_reg} * {{PREV_W{1'b0}}, diff_reg};
        end
        if (cmd.accum) begin
            if (have_prev_reg) begin
                if (count_reg < COUNT_W'(MAX_DIFFS)) begin
                    sum_next   = sum_reg + SUM_W'(sq_reg);
                    count_next = count_reg + 1'b1;
                end else begin
                    ovf_next = 1'b1;
                end
            end
            prev_next      = cur_reg;
            have_prev_next = 1'b1;
        end
        // result taken into the output register: start a fresh record
        if (cmd.emit) begin
            prev_next      = '0;
            have_prev_next = 1'b0;
            sum_next       = '0;
            count_next     = '0;
            ovf_next       = 1'b0;
        end
    end

    // Scaled mean: sum * 2^(2*FRAC_BITS) / count, saturated to 64 bits
    assign div_dividend = DIVD_W'(sum_reg) << (2 * FRAC_BITS);
    assign mean = ((div_quot >> SUM_W) != '0) ? '1 : div_quot[SUM_W-1:0];

    rha_divider #(
        .DIVD_W   (DIVD_W),
        .DIVS_W   (COUNT_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    rha_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sqrt_start),
        .radicand (mean),
        .done     (sqrt_done),
        .root     (root)
    );

    assign root_sat = (root[ROOT_W-1:ROOT_OUT_W] != '0) ? '1 : root[ROOT_OUT_W-1:0];

    // Output register: loaded on emit, freed when the word is taken
    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
            if (count_reg == '0) begin
                m_item_next.rmssd_q4   = '0;
                m_item_next.diff_count = '0;
                m_item_next.status     = rha_pkg::STATUS_TOO_FEW;
            end else begin
                m_item_next.rmssd_q4   = root_sat;
                m_item_next.diff_count = rha_pkg::COUNT_OUT_W'(count_reg);
                m_item_next.status     = ovf_reg ? rha_pkg::STATUS_TOO_MANY
                                                 : rha_pkg::STATUS_OK;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            sum_reg       <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            m_valid_reg   <= m_valid_next;
        end
        cur_reg    <= cur_next;
        last_reg   <= last_next;
        diff_reg   <= diff_next;
        sq_reg     <= sq_next;
        m_item_reg <= m_item_next;
    end

    // Status back to the controller
    always_comb begin
        sts.last       = last_reg;
        sts.count_zero = (count_reg == '0);
        sts.div_done   = div_done;
        sts.sqrt_done  = sqrt_done;
        sts.out_busy   = m_valid_reg && !m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

### hw/rtl/rha_ctrl.sv
// ============================================================================
// rha_ctrl
// Sequencing state machine: per-interval accumulate steps, then divide,
// root and result hand-off on the final interval of a record.
// ============================================================================
module rha_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rha_pkg::ctrl_sts_t  sts,
    output rha_pkg::ctrl_cmd_t  cmd
);

    rha_pkg::state_t state_reg, state_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rha_pkg::ST_IDLE: begin
                if (s_valid) state_next = rha_pkg::ST_DIFF;
            end
            rha_pkg::ST_DIFF:   state_next = rha_pkg::ST_SQUARE;
            rha_pkg::ST_SQUARE: state_next = rha_pkg::ST_ACCUM;
            rha_pkg::ST_ACCUM: begin
                state_next = sts.last ? rha_pkg::ST_LOAD : rha_pkg::ST_IDLE;
            end
            rha_pkg::ST_LOAD: begin
                state_next = sts.count_zero ? rha_pkg::ST_FINISH : rha_pkg::ST_DIVIDE;
            end
            rha_pkg::ST_DIVIDE: begin
                if (sts.div_done) state_next = rha_pkg::ST_ROOT;
            end
            rha_pkg::ST_ROOT: begin
                if (sts.sqrt_done) state_next = rha_pkg::ST_FINISH;
            end
            rha_pkg::ST_FINISH: begin
                if (!sts.out_busy) state_next = rha_pkg::ST_IDLE;
            end
            default: state_next = rha_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            rha_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            rha_pkg::ST_DIFF:   cmd.diff   = 1'b1;
            rha_pkg::ST_SQUARE: cmd.square = 1'b1;
            rha_pkg::ST_ACCUM:  cmd.accum  = 1'b1;
            rha_pkg::ST_LOAD:   cmd.div_start = !sts.count_zero;
            rha_pkg::ST_DIVIDE: cmd.sqrt_start = sts.div_done;
            rha_pkg::ST_ROOT:   ;
            rha_pkg::ST_FINISH: cmd.emit = !sts.out_busy;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rha_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
